FILE: src/indexed_list_insert_delete_macros.svh
// ----------------------------------------------------------------------------
// Indexed list assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_INSERT_DELETE_MACROS_SVH
`define INDEXED_LIST_INSERT_DELETE_MACROS_SVH

// same-cycle implication
`define ILID_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("indexed list check failed");

// next-cycle implication
`define ILID_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("indexed list check failed");

`endif

FILE: src/ilid_pkg.sv
// ----------------------------------------------------------------------------
// Indexed list package
// Field widths, operation codes and the controller-to-datapath command.
// ----------------------------------------------------------------------------
package ilid_pkg;

  localparam int OP_W  = 3;
  localparam int POS_W = 5;
  localparam int VAL_W = 32;
  localparam int LEN_W = 5;

  localparam logic [OP_W-1:0] OP_READ     = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd2;
  localparam logic [OP_W-1:0] OP_INS_AT   = 3'd3;
  localparam logic [OP_W-1:0] OP_DELETE   = 3'd4;

  typedef struct packed {
    logic load;
    logic exec;
  } ilid_cmd_t;

endpackage

FILE: src/ilid_ctrl.sv
// ----------------------------------------------------------------------------
// Indexed list controller
// Command register occupancy and result register handshake.
// ----------------------------------------------------------------------------
module ilid_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output ilid_pkg::ilid_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_BUSY = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign cmd.exec = (state_r == S_BUSY) && out_free;
  assign in_stall = (state_r == S_BUSY) && !out_free;
  assign cmd.load = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    unique case (state_r)
      S_IDLE: state_nxt = cmd.load ? S_BUSY : S_IDLE;
      S_BUSY: state_nxt = (cmd.load || !cmd.exec) ? S_BUSY : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.exec || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: src/ilid_dpath.sv
// ----------------------------------------------------------------------------
// Indexed list datapath
// Command register, entry array with parallel shift, length and result.
// ----------------------------------------------------------------------------
module ilid_dpath #(
  parameter int CAPACITY = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ilid_pkg::ilid_cmd_t              cmd,
  input  logic [ilid_pkg::OP_W-1:0]        in_operation,
  input  logic [ilid_pkg::POS_W-1:0]       in_position,
  input  logic signed [ilid_pkg::VAL_W-1:0] in_item_value,
  output logic signed [ilid_pkg::VAL_W-1:0] out_read_value,
  output logic                             out_hit,
  output logic                             out_applied,
  output logic                             out_full_refused,
  output logic [ilid_pkg::LEN_W-1:0]       out_list_length
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > ilid_pkg::POS_W) ? CW : ilid_pkg::POS_W;
  localparam int RDN  = (CAPACITY < (1 << ilid_pkg::POS_W)) ? CAPACITY
                                                          : (1 << ilid_pkg::POS_W);

  logic [ilid_pkg::OP_W-1:0]         op_r;
  logic [ilid_pkg::POS_W-1:0]        pos_r;
  logic signed [ilid_pkg::VAL_W-1:0] val_r;
  logic [CW-1:0]                     count_r, count_nxt;
  logic signed [ilid_pkg::VAL_W-1:0] ent_r   [CAPACITY];
  logic signed [ilid_pkg::VAL_W-1:0] ent_nxt [CAPACITY];

  logic [CMPW-1:0] pos_ext, count_ext, where;
  logic            is_ins, full, ins_in_range, ins_ok, refused, del_ok, rd_hit;
  logic signed [ilid_pkg::VAL_W-1:0] rd_mux, rd_val;

  logic signed [ilid_pkg::VAL_W-1:0] rd_val_r;
  logic                              hit_r, applied_r, refused_r;
  logic [ilid_pkg::LEN_W-1:0]        len_r;

  always_comb begin
    pos_ext   = CMPW'(pos_r);
    count_ext = CMPW'(count_r);
    full      = (count_r == CW'(CAPACITY));
    is_ins    = 1'b0;
    where     = '0;
    unique case (op_r)
      ilid_pkg::OP_INS_HEAD: begin
        is_ins = 1'b1;
        where  = '0;
      end
      ilid_pkg::OP_INS_TAIL: begin
        is_ins = 1'b1;
        where  = count_ext;
      end
      ilid_pkg::OP_INS_AT: begin
        is_ins = 1'b1;
        where  = pos_ext;
      end
      default: begin
        is_ins = 1'b0;
        where  = pos_ext;
      end
    endcase
    ins_in_range = is_ins && (where <= count_ext);
    ins_ok       = ins_in_range && !full;
    refused      = ins_in_range && full;
    del_ok       = (op_r == ilid_pkg::OP_DELETE) && (pos_ext < count_ext);
    rd_hit       = (op_r == ilid_pkg::OP_READ) && (pos_ext < count_ext);

    rd_mux = '1;
    for (int k = 0; k < RDN; k++) begin
      if (pos_r == ilid_pkg::POS_W'(k)) rd_mux = ent_r[k];
    end
    rd_val = rd_hit ? rd_mux : '1;

    // each entry takes its own value, its neighbor, or the new value
    for (int k = 0; k < CAPACITY; k++) ent_nxt[k] = ent_r[k];
    if (ins_ok) begin
      if (where == '0) ent_nxt[0] = val_r;
      for (int k = 1; k < CAPACITY; k++) begin
        if (CMPW'(k) > where)       ent_nxt[k] = ent_r[k-1];
        else if (CMPW'(k) == where) ent_nxt[k] = val_r;
      end
    end else if (del_ok) begin
      for (int k = 0; k < CAPACITY - 1; k++) begin
        if (CMPW'(k) >= pos_ext) ent_nxt[k] = ent_r[k+1];
      end
    end

    if (ins_ok)      count_nxt = count_r + CW'(1);
    else if (del_ok) count_nxt = count_r - CW'(1);
    else             count_nxt = count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_operation;
      pos_r <= in_position;
      val_r <= in_item_value;
    end
    if (cmd.exec) begin
      ent_r     <= ent_nxt;
      rd_val_r  <= rd_val;
      hit_r     <= rd_hit;
      applied_r <= ins_ok || del_ok;
      refused_r <= refused;
      len_r     <= ilid_pkg::LEN_W'(count_nxt);
    end
  end

  assign out_read_value   = rd_val_r;
  assign out_hit          = hit_r;
  assign out_applied      = applied_r;
  assign out_full_refused = refused_r;
  assign out_list_length  = len_r;

endmodule

FILE: src/indexed_list_insert_delete.sv
// ----------------------------------------------------------------------------
// Indexed list insert/delete
// Ordered list of signed 32-bit values with read, insert and delete by
// position; one result per command.
// ----------------------------------------------------------------------------
// A command is captured into the command register when accepted and executed
// once the result register is free: every entry loads itself, its neighbor
// or the new value at once, so a whole insert or delete completes in that
// execute step. out_valid rises when the result register loads, and a new
// command is taken every cycle while results are drained, one command per
// cycle sustained. Stalling the result side holds the command register
// full.
// Entries are not reset; only positions below the length are ever read.
module indexed_list_insert_delete #(
  parameter int CAPACITY = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ilid_pkg::OP_W-1:0]         in_operation,
  input  logic [ilid_pkg::POS_W-1:0]        in_position,
  input  logic signed [ilid_pkg::VAL_W-1:0] in_item_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [ilid_pkg::VAL_W-1:0] out_read_value,
  output logic                              out_hit,
  output logic                              out_applied,
  output logic                              out_full_refused,
  output logic [ilid_pkg::LEN_W-1:0]        out_list_length
);

  ilid_pkg::ilid_cmd_t cmd;

  ilid_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  ilid_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_operation     (in_operation),
    .in_position      (in_position),
    .in_item_value    (in_item_value),
    .out_read_value   (out_read_value),
    .out_hit          (out_hit),
    .out_applied      (out_applied),
    .out_full_refused (out_full_refused),
    .out_list_length  (out_list_length)
  );

endmodule

FILE: src/ilid_chk.sv
// ----------------------------------------------------------------------------
// Indexed list checker
// Port-level checks on result consistency and the result handshake.
// ----------------------------------------------------------------------------
`include "indexed_list_insert_delete_macros.svh"

module ilid_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [ilid_pkg::VAL_W-1:0] out_read_value,
  input logic                              out_hit,
  input logic                              out_applied,
  input logic                              out_full_refused,
  input logic [ilid_pkg::LEN_W-1:0]        out_list_length
);

  `ILID_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_read_value) && $stable(out_list_length) && $stable(out_hit))
  `ILID_ASSERT_SAME(a_miss_all_ones, out_valid && !out_hit, out_read_value == '1)
  `ILID_ASSERT_SAME(a_hit_no_change, out_valid && out_hit, !out_applied && !out_full_refused)
  `ILID_ASSERT_SAME(a_refuse_excl, out_valid && out_full_refused, !out_applied && !out_hit)

endmodule

bind indexed_list_insert_delete ilid_chk u_ilid_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_read_value   (out_read_value),
  .out_hit          (out_hit),
  .out_applied      (out_applied),
  .out_full_refused (out_full_refused),
  .out_list_length  (out_list_length)
);

FILE: bench/indexed_list_insert_delete_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Indexed list insert/delete testbench
// Drives read, insert and delete commands through the valid/stall input
// channel, mirrors the list in a shadow copy to predict each result, and
// checks all fields of every result transfer in arrival order. Runs a
// directed pass over empty, full and out-of-range cases, then random traffic
// that sweeps the list between empty and full under several idle/stall mixes.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete_tb;

  localparam int LIST_CAP = 16;
  localparam int IDX_W = $clog2(LIST_CAP);
  localparam int RAND_PER_PHASE = 325;
  localparam int MAX_REPORTS = 10;
  localparam logic [ilid_pkg::OP_W-1:0] OP_LAST = 3'd7;

  typedef struct packed {
    logic signed [ilid_pkg::VAL_W-1:0] read_value;
    logic                              hit;
    logic                              applied;
    logic                              full_refused;
    logic [ilid_pkg::LEN_W-1:0]        list_length;
  } list_result_t;

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_stall;
  logic [ilid_pkg::OP_W-1:0]         in_operation;
  logic [ilid_pkg::POS_W-1:0]        in_position;
  logic signed [ilid_pkg::VAL_W-1:0] in_item_value;
  logic                              out_valid;
  logic                              out_stall;
  logic signed [ilid_pkg::VAL_W-1:0] out_read_value;
  logic                              out_hit;
  logic                              out_applied;
  logic                              out_full_refused;
  logic [ilid_pkg::LEN_W-1:0]        out_list_length;

  logic signed [ilid_pkg::VAL_W-1:0] shadow_entries [LIST_CAP];
  int unsigned                       shadow_len;
  list_result_t                      pending_results [$];
  list_result_t                      got_result;
  list_result_t                      want_result;
  int                                mismatch_count;
  int                                send_idle_pct;
  int                                stall_pct;
  bit                                grow_bias;

  indexed_list_insert_delete #(
    .CAPACITY(LIST_CAP)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_position     (in_position),
    .in_item_value   (in_item_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_read_value  (out_read_value),
    .out_hit         (out_hit),
    .out_applied     (out_applied),
    .out_full_refused(out_full_refused),
    .out_list_length (out_list_length)
  );

  always #10 clk = ~clk;

  function automatic list_result_t list_apply(logic [ilid_pkg::OP_W-1:0] op,
                                              logic [ilid_pkg::POS_W-1:0] pos,
                                              logic signed [ilid_pkg::VAL_W-1:0] val);
    list_result_t r;
    int unsigned  where;
    int unsigned  k;
    r.read_value   = '1;
    r.hit          = 1'b0;
    r.applied      = 1'b0;
    r.full_refused = 1'b0;
    where = 32'(pos);
    case (op)
      ilid_pkg::OP_READ: begin
        if (where < shadow_len) begin
          r.read_value = shadow_entries[IDX_W'(where)];
          r.hit        = 1'b1;
        end
      end
      ilid_pkg::OP_INS_HEAD, ilid_pkg::OP_INS_TAIL, ilid_pkg::OP_INS_AT: begin
        if (op == ilid_pkg::OP_INS_HEAD) where = 0;
        else if (op == ilid_pkg::OP_INS_TAIL) where = shadow_len;
        if (where <= shadow_len) begin
          if (shadow_len >= LIST_CAP) begin
            r.full_refused = 1'b1;
          end else begin
            for (k = shadow_len; k > where; k--)
              shadow_entries[IDX_W'(k)] = shadow_entries[IDX_W'(k-1)];
            shadow_entries[IDX_W'(where)] = val;
            shadow_len++;
            r.applied = 1'b1;
          end
        end
      end
      ilid_pkg::OP_DELETE: begin
        if (where < shadow_len) begin
          for (k = where; k + 1 < shadow_len; k++)
            shadow_entries[IDX_W'(k)] = shadow_entries[IDX_W'(k+1)];
          shadow_len--;
          r.applied = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.list_length = shadow_len[ilid_pkg::LEN_W-1:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int g;
    g = 0;
    while (g < 20 && $urandom_range(99) < send_idle_pct) g++;
    return g;
  endfunction

  task automatic send_cmd(logic [ilid_pkg::OP_W-1:0] op, logic [ilid_pkg::POS_W-1:0] pos,
                          logic signed [ilid_pkg::VAL_W-1:0] val);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_position   <= pos;
    in_item_value <= val;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(list_apply(op, pos, val));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic signed [ilid_pkg::VAL_W-1:0] pick_value();
    logic [2:0] sel;
    if ($urandom_range(9) != 0) return $urandom;
    sel = 3'($urandom_range(5));
    case (sel)
      3'd0:    return 32'sh8000_0000;
      3'd1:    return 32'sh7FFF_FFFF;
      3'd2:    return '0;
      3'd3:    return '1;
      3'd4:    return 32'sh5555_5555;
      default: return 32'shAAAA_AAAA;
    endcase
  endfunction

  // empty list: a read, delete and insert beyond length, an unused code
  task automatic test_empty_list();
    send_cmd(ilid_pkg::OP_READ, 5'd0, '0);
    send_cmd(ilid_pkg::OP_DELETE, 5'd0, '1);
    send_cmd(ilid_pkg::OP_INS_AT, 5'd1, 32'sh1234_5678);
    send_cmd(OP_LAST, 5'd31, 32'sh7FFF_FFFF);
  endtask

  // fill to capacity through every insert form, then refusals, edge reads and deletes
  task automatic test_fill_to_full();
    int i;
    send_cmd(ilid_pkg::OP_INS_TAIL, 5'd0, 32'sh8000_0000);
    send_cmd(ilid_pkg::OP_INS_HEAD, 5'd0, 32'sh7FFF_FFFF);
    send_cmd(ilid_pkg::OP_INS_AT, 5'd1, 32'sh5555_5555);
    send_cmd(ilid_pkg::OP_INS_AT, 5'd3, 32'shAAAA_AAAA);
    for (i = 4; i < LIST_CAP; i++) send_cmd(ilid_pkg::OP_INS_TAIL, 5'(i), pick_value());
    send_cmd(ilid_pkg::OP_INS_HEAD, 5'd0, '1);
    send_cmd(ilid_pkg::OP_INS_AT, 5'd16, '0);
    send_cmd(ilid_pkg::OP_INS_AT, 5'd17, '0);
    send_cmd(ilid_pkg::OP_READ, 5'd15, '0);
    send_cmd(ilid_pkg::OP_READ, 5'd16, '0);
    send_cmd(ilid_pkg::OP_DELETE, 5'd0, '0);
    send_cmd(ilid_pkg::OP_DELETE, 5'd14, '0);
  endtask

  task automatic test_random_traffic(int count, int idle_pct, int stall_mix);
    int                         i;
    int                         r;
    logic [ilid_pkg::OP_W-1:0]  op;
    logic [ilid_pkg::POS_W-1:0] pos;
    send_idle_pct = idle_pct;
    stall_pct     = stall_mix;
    for (i = 0; i < count; i++) begin
      if (shadow_len == LIST_CAP) grow_bias = 1'b0;
      else if (shadow_len == 0) grow_bias = 1'b1;
      else if ($urandom_range(49) == 0) grow_bias = ~grow_bias;
      r = $urandom_range(99);
      if (r < 5) op = 3'($urandom_range(OP_LAST, ilid_pkg::OP_DELETE + 1));
      else if (r < 25) op = ilid_pkg::OP_READ;
      else if ((r < 85) == grow_bias)
        op = 3'($urandom_range(ilid_pkg::OP_INS_AT, ilid_pkg::OP_INS_HEAD));
      else op = ilid_pkg::OP_DELETE;
      r = $urandom_range(99);
      if (r < 80) pos = 5'($urandom_range(shadow_len));
      else if (r < 95) pos = 5'($urandom_range(LIST_CAP));
      else pos = 5'($urandom_range(31));
      send_cmd(op, pos, pick_value());
    end
  endtask

  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_result = {out_read_value, out_hit, out_applied, out_full_refused, out_list_length};
      if (pending_results.size() == 0) begin
        if (mismatch_count < MAX_REPORTS)
          $display("unexpected result transfer: read_value=%0d hit=%b applied=%b full=%b len=%0d",
                   got_result.read_value, got_result.hit, got_result.applied,
                   got_result.full_refused, got_result.list_length);
        mismatch_count++;
      end else begin
        want_result = pending_results.pop_front();
        if (got_result !== want_result) begin
          if (mismatch_count < MAX_REPORTS)
            $display({"result mismatch: exp read_value=%0d hit=%b applied=%b full=%b len=%0d",
                      " | got read_value=%0d hit=%b applied=%b full=%b len=%0d"},
                     want_result.read_value, want_result.hit, want_result.applied,
                     want_result.full_refused, want_result.list_length,
                     got_result.read_value, got_result.hit, got_result.applied,
                     got_result.full_refused, got_result.list_length);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("indexed_list_insert_delete: mismatch");
    $finish;
  end

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_operation   = ilid_pkg::OP_READ;
    in_position    = '0;
    in_item_value  = '0;
    shadow_len     = 0;
    mismatch_count = 0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    grow_bias      = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_list();
    test_fill_to_full();
    wait_drained();
    test_random_traffic(RAND_PER_PHASE, 0, 0);
    wait_drained();
    test_random_traffic(RAND_PER_PHASE, 56, 0);
    test_random_traffic(RAND_PER_PHASE, 0, 56);
    wait_drained();
    test_random_traffic(RAND_PER_PHASE, 31, 31);

    stall_pct = 0;
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("indexed_list_insert_delete: match");
    else
      $display("indexed_list_insert_delete: mismatch");
    $finish;
  end

endmodule
